### rtl/ibh_pkg.sv
// shared constants, codes and types of the indexed binary heap unit
package ibh_pkg;
   localparam int CAPACITY   = 256;
   localparam int NUM_IDS    = 1024;
   localparam int KEY_BITS   = 32;
   localparam int SLOT_BITS  = $clog2(CAPACITY);
   localparam int ID_BITS    = $clog2(NUM_IDS);
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int FUNC_BITS  = 3;
   localparam int STAT_BITS  = 3;

   localparam logic [FUNC_BITS-1:0] FUNC_PUSH  = 3'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_POP   = 3'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_DEC   = 3'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_INC   = 3'd3;
   localparam logic [FUNC_BITS-1:0] FUNC_CLEAR = 3'd4;

   localparam logic [STAT_BITS-1:0] STAT_OK      = 3'd0;
   localparam logic [STAT_BITS-1:0] STAT_EMPTY   = 3'd1;
   localparam logic [STAT_BITS-1:0] STAT_FULL    = 3'd2;
   localparam logic [STAT_BITS-1:0] STAT_PRESENT = 3'd3;
   localparam logic [STAT_BITS-1:0] STAT_ABSENT  = 3'd4;

   typedef struct packed {
      logic [ID_BITS-1:0]  id;
      logic [KEY_BITS-1:0] key;
   } slot_type;

   localparam int SLOT_WIDTH = $bits(slot_type);
endpackage

### rtl/ibh_ram.sv
// generic single write port ram with registered read
module ibh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

### rtl/ibh_compare.sv
// shared key comparator: true when key a belongs strictly above key b
module ibh_compare (
   input  logic                        min_order,
   input  logic [ibh_pkg::KEY_BITS-1:0] key_a,
   input  logic [ibh_pkg::KEY_BITS-1:0] key_b,
   output logic                        above
);
   import ibh_pkg::*;

   always_comb begin
      if (min_order) begin
         above = key_a < key_b;
      end else begin
         above = key_a > key_b;
      end
   end
endmodule

### rtl/indexed_binary_heap_unit.sv
// indexed binary heap unit: sequencer, heap and id position memories
// push climbs toward the root; re-key climbs, or sifts down if it did not move up;
// pop takes the top, moves the last entry to the root and sifts it down
// one request at a time, set by the single read port of the heap memory
// after reset a sweep clears all 1024 entries of the position table, busy stays high
// each response is shown for one cycle on rsp_strobe, the receiver cannot stall
module indexed_binary_heap_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [ibh_pkg::FUNC_BITS-1:0]  req_func,
   input  logic [ibh_pkg::ID_BITS-1:0]    req_item_id,
   input  logic [ibh_pkg::KEY_BITS-1:0]   req_item_key,
   output logic                           rsp_strobe,
   output logic [ibh_pkg::STAT_BITS-1:0]  rsp_status,
   output logic [ibh_pkg::ID_BITS-1:0]    rsp_top_id,
   output logic [ibh_pkg::KEY_BITS-1:0]   rsp_top_key,
   output logic [ibh_pkg::COUNT_BITS-1:0] rsp_entry_count,
   input  logic                           csr_we,
   input  logic                           csr_wdata
);
   import ibh_pkg::*;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_POS_RD, S_POS_WT, S_CHK, S_UP, S_UP_CMP, S_DN, S_DN_C1,
      S_DN_C2, S_DN_CMP, S_PLACE, S_TOP_RD, S_TOP_WT, S_LAST_WT
   } state_type;

   state_type              state_ff, state_in;
   logic                   min_order_ff;
   logic [ID_BITS-1:0]     sweep_ff, sweep_in;
   logic [COUNT_BITS-1:0]  fill_ff, fill_in;
   logic [FUNC_BITS-1:0]   func_ff, func_in;
   slot_type               cur_ff, cur_in;
   slot_type               pick_ff, pick_in;
   logic [SLOT_BITS-1:0]   pos_ff, pos_in;
   logic [SLOT_BITS-1:0]   pick_pos_ff, pick_pos_in;
   logic                   moved_ff, moved_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [STAT_BITS-1:0]   rsp_status_ff, rsp_status_in;
   slot_type               top_ff, top_in;
   logic [COUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;

   logic                   heap_we;
   logic [SLOT_BITS-1:0]   heap_waddr, heap_raddr;
   slot_type               heap_wdata, heap_rdata;
   logic                   pos_we;
   logic [ID_BITS-1:0]     pos_waddr, pos_raddr;
   logic [SLOT_BITS-1:0]   pos_wdata, pos_rdata;

   logic [KEY_BITS-1:0]    cmp_a, cmp_b;
   logic                   cmp_above;
   logic [COUNT_BITS-1:0]  c1_w, c2_w;
   logic [SLOT_BITS-1:0]   parent_w;
   logic                   is_rekey;
   logic                   present;

   ibh_ram #(.WIDTH(SLOT_WIDTH), .DEPTH(CAPACITY)) u_heap_ram (
      .clock   (clock),
      .wr_en   (heap_we),
      .wr_addr (heap_waddr),
      .wr_data (heap_wdata),
      .rd_addr (heap_raddr),
      .rd_data (heap_rdata)
   );

   ibh_ram #(.WIDTH(SLOT_BITS), .DEPTH(NUM_IDS)) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (pos_waddr),
      .wr_data (pos_wdata),
      .rd_addr (pos_raddr),
      .rd_data (pos_rdata)
   );

   ibh_compare u_compare (
      .min_order (min_order_ff),
      .key_a     (cmp_a),
      .key_b     (cmp_b),
      .above     (cmp_above)
   );

   assign c1_w     = {pos_ff, 1'b1};
   assign c2_w     = c1_w + COUNT_BITS'(1);
   assign parent_w = (pos_ff - SLOT_BITS'(1)) >> 1;
   assign is_rekey = (func_ff == FUNC_DEC) || (func_ff == FUNC_INC);
   assign present  = (COUNT_BITS'(pos_ff) < fill_ff) && (heap_rdata.id == cur_ff.id);

   always_comb begin
      cmp_a = heap_rdata.key;
      cmp_b = pick_ff.key;
      case (state_ff)
         S_UP_CMP: begin
            cmp_a = cur_ff.key;
            cmp_b = heap_rdata.key;
         end
         S_DN_CMP: begin
            cmp_a = pick_ff.key;
            cmp_b = cur_ff.key;
         end
         default: begin
            cmp_a = heap_rdata.key;
            cmp_b = pick_ff.key;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      fill_in       = fill_ff;
      func_in       = func_ff;
      cur_in        = cur_ff;
      pick_in       = pick_ff;
      pos_in        = pos_ff;
      pick_pos_in   = pick_pos_ff;
      moved_in      = moved_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      top_in        = top_ff;
      rsp_count_in  = rsp_count_ff;
      heap_we       = 1'b0;
      heap_waddr    = pos_ff;
      heap_wdata    = cur_ff;
      heap_raddr    = '0;
      pos_we        = 1'b0;
      pos_waddr     = cur_ff.id;
      pos_wdata     = pos_ff;
      pos_raddr     = cur_ff.id;

      case (state_ff)
         S_INIT: begin
            pos_we    = 1'b1;
            pos_waddr = sweep_ff;
            pos_wdata = '0;
            sweep_in  = sweep_ff + ID_BITS'(1);
            if (sweep_ff == ID_BITS'(NUM_IDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               func_in     = req_func;
               cur_in.id   = req_item_id;
               cur_in.key  = req_item_key;
               moved_in    = 1'b0;
               top_in      = '0;
               case (req_func)
                  FUNC_PUSH, FUNC_DEC, FUNC_INC: begin
                     state_in = S_POS_RD;
                  end
                  FUNC_POP: begin
                     if (fill_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                        rsp_count_in  = fill_ff;
                     end else begin
                        state_in = S_TOP_RD;
                     end
                  end
                  FUNC_CLEAR: begin
                     fill_in       = '0;
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STAT_OK;
                     rsp_count_in  = '0;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STAT_OK;
                     rsp_count_in  = fill_ff;
                  end
               endcase
            end
         end
         S_POS_RD: begin
            pos_raddr = cur_ff.id;
            state_in  = S_POS_WT;
         end
         S_POS_WT: begin
            heap_raddr = pos_rdata;
            pos_in     = pos_rdata;
            state_in   = S_CHK;
         end
         S_CHK: begin
            if (is_rekey) begin
               if (!present) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STAT_ABSENT;
                  rsp_count_in  = fill_ff;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_UP;
               end
            end else if (present) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STAT_PRESENT;
               rsp_count_in  = fill_ff;
               state_in      = S_IDLE;
            end else if (fill_ff == COUNT_BITS'(CAPACITY)) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STAT_FULL;
               rsp_count_in  = fill_ff;
               state_in      = S_IDLE;
            end else begin
               pos_in   = fill_ff[SLOT_BITS-1:0];
               fill_in  = fill_ff + COUNT_BITS'(1);
               state_in = S_UP;
            end
         end
         S_UP: begin
            heap_raddr = parent_w;
            if (pos_ff == '0) begin
               state_in = (is_rekey && !moved_ff) ? S_DN : S_PLACE;
            end else begin
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (cmp_above) begin
               heap_we    = 1'b1;
               heap_waddr = pos_ff;
               heap_wdata = heap_rdata;
               pos_we     = 1'b1;
               pos_waddr  = heap_rdata.id;
               pos_wdata  = pos_ff;
               pos_in     = parent_w;
               moved_in   = 1'b1;
               state_in   = S_UP;
            end else begin
               state_in = (is_rekey && !moved_ff) ? S_DN : S_PLACE;
            end
         end
         S_DN: begin
            heap_raddr = c1_w[SLOT_BITS-1:0];
            state_in   = (c1_w >= fill_ff) ? S_PLACE : S_DN_C1;
         end
         S_DN_C1: begin
            pick_in     = heap_rdata;
            pick_pos_in = c1_w[SLOT_BITS-1:0];
            heap_raddr  = c2_w[SLOT_BITS-1:0];
            state_in    = (c2_w < fill_ff) ? S_DN_C2 : S_DN_CMP;
         end
         S_DN_C2: begin
            if (cmp_above) begin
               pick_in     = heap_rdata;
               pick_pos_in = c2_w[SLOT_BITS-1:0];
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (cmp_above) begin
               heap_we    = 1'b1;
               heap_waddr = pos_ff;
               heap_wdata = pick_ff;
               pos_we     = 1'b1;
               pos_waddr  = pick_ff.id;
               pos_wdata  = pos_ff;
               pos_in     = pick_pos_ff;
               state_in   = S_DN;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            heap_we       = 1'b1;
            heap_waddr    = pos_ff;
            heap_wdata    = cur_ff;
            pos_we        = 1'b1;
            pos_waddr     = cur_ff.id;
            pos_wdata     = pos_ff;
            rsp_strobe_in = 1'b1;
            rsp_status_in = STAT_OK;
            rsp_count_in  = fill_ff;
            state_in      = S_IDLE;
         end
         S_TOP_RD: begin
            heap_raddr = '0;
            state_in   = S_TOP_WT;
         end
         S_TOP_WT: begin
            top_in     = heap_rdata;
            fill_in    = fill_ff - COUNT_BITS'(1);
            heap_raddr = fill_in[SLOT_BITS-1:0];
            if (fill_ff == COUNT_BITS'(1)) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_count_in  = '0;
               state_in      = S_IDLE;
            end else begin
               state_in = S_LAST_WT;
            end
         end
         S_LAST_WT: begin
            cur_in   = heap_rdata;
            pos_in   = '0;
            state_in = S_DN;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         sweep_ff      <= '0;
         fill_ff       <= '0;
         min_order_ff  <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         fill_ff       <= fill_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we) begin
            min_order_ff <= csr_wdata;
         end
      end
      func_ff       <= func_in;
      cur_ff        <= cur_in;
      pick_ff       <= pick_in;
      pos_ff        <= pos_in;
      pick_pos_ff   <= pick_pos_in;
      moved_ff      <= moved_in;
      rsp_status_ff <= rsp_status_in;
      top_ff        <= top_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy            = state_ff != S_IDLE;
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_top_id      = top_ff.id;
   assign rsp_top_key     = top_ff.key;
   assign rsp_entry_count = rsp_count_ff;
endmodule

### rtl/ibh_checker.sv
// port level checks of the indexed binary heap unit and their bind
module ibh_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_strobe,
   input logic [ibh_pkg::STAT_BITS-1:0]  rsp_status,
   input logic [ibh_pkg::ID_BITS-1:0]    rsp_top_id,
   input logic [ibh_pkg::KEY_BITS-1:0]   rsp_top_key,
   input logic [ibh_pkg::COUNT_BITS-1:0] rsp_entry_count
);
   import ibh_pkg::*;

   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy || rsp_strobe)
      else $error("request accepted without work or response");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while busy");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_entry_count <= COUNT_BITS'(CAPACITY))
      else $error("entry count beyond capacity");

   a_top_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != STAT_OK) |-> (rsp_top_id == '0 && rsp_top_key == '0))
      else $error("top fields set on failed request");
endmodule

bind indexed_binary_heap_unit ibh_checker u_ibh_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_status      (rsp_status),
   .rsp_top_id      (rsp_top_id),
   .rsp_top_key     (rsp_top_key),
   .rsp_entry_count (rsp_entry_count)
);

### bench/tb_indexed_binary_heap_unit.sv
// self-checking testbench of the indexed binary heap unit
module tb_indexed_binary_heap_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import ibh_pkg::*;

   typedef struct packed {
      logic [STAT_BITS-1:0]  status;
      logic [ID_BITS-1:0]    top_id;
      logic [KEY_BITS-1:0]   top_key;
      logic [COUNT_BITS-1:0] entry_count;
   } heap_reply_type;

   typedef struct {
      logic [FUNC_BITS-1:0] func;
      logic [ID_BITS-1:0]   id;
      logic [KEY_BITS-1:0]  key;
      bit                   typed;
      heap_reply_type       reply;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [FUNC_BITS-1:0]  req_func = '0;
   logic [ID_BITS-1:0]    req_item_id = '0;
   logic [KEY_BITS-1:0]   req_item_key = '0;
   logic rsp_strobe;
   logic [STAT_BITS-1:0]  rsp_status;
   logic [ID_BITS-1:0]    rsp_top_id;
   logic [KEY_BITS-1:0]   rsp_top_key;
   logic [COUNT_BITS-1:0] rsp_entry_count;
   logic csr_we = 0;
   logic csr_wdata = 0;

   indexed_binary_heap_unit uut (.*);

   always #2 clock = ~clock;

   // predictor state
   logic [ID_BITS-1:0]    heap_ids [CAPACITY];
   logic [KEY_BITS-1:0]   heap_keys[CAPACITY];
   int                    id_slot  [NUM_IDS];
   bit                    id_held  [NUM_IDS];
   int                    heap_fill;
   bit                    smallest_on_top;

   heap_reply_type pending_replies[$];
   int errors = 0;

   function automatic bit outranks(logic [KEY_BITS-1:0] a, logic [KEY_BITS-1:0] b);
      return smallest_on_top ? (a < b) : (a > b);
   endfunction

   function automatic void swap_slots(int p, int q);
      logic [ID_BITS-1:0] ti;
      logic [KEY_BITS-1:0] tk;
      ti = heap_ids[p]; tk = heap_keys[p];
      heap_ids[p] = heap_ids[q]; heap_keys[p] = heap_keys[q];
      heap_ids[q] = ti; heap_keys[q] = tk;
      id_slot[heap_ids[p]] = p;
      id_slot[heap_ids[q]] = q;
   endfunction

   function automatic bit climb(int pos);
      bit moved;
      int parent;
      moved = 0;
      while (pos > 0) begin
         parent = (pos - 1) >> 1;
         if (!outranks(heap_keys[pos], heap_keys[parent])) break;
         swap_slots(parent, pos);
         pos = parent;
         moved = 1;
      end
      return moved;
   endfunction

   function automatic void sink(int pos);
      int pick;
      while (pos < (heap_fill >> 1)) begin
         pick = pos * 2 + 1;
         if (pick + 1 < heap_fill && outranks(heap_keys[pick + 1], heap_keys[pick]))
            pick = pick + 1;
         if (!outranks(heap_keys[pick], heap_keys[pos])) break;
         swap_slots(pos, pick);
         pos = pick;
      end
   endfunction

   function automatic void empty_heap();
      foreach (id_held[i]) begin
         id_held[i] = 0;
         id_slot[i] = 0;
      end
      heap_fill = 0;
   endfunction

   function automatic heap_reply_type apply_request(logic [FUNC_BITS-1:0] func,
                                                    logic [ID_BITS-1:0] id,
                                                    logic [KEY_BITS-1:0] key);
      heap_reply_type r;
      int pos;
      r = '0;
      r.status = STAT_OK;
      case (func)
         FUNC_PUSH: begin
            if (id_held[id]) r.status = STAT_PRESENT;
            else if (heap_fill >= CAPACITY) r.status = STAT_FULL;
            else begin
               pos = heap_fill;
               heap_ids[pos] = id; heap_keys[pos] = key;
               id_slot[id] = pos; id_held[id] = 1;
               heap_fill++;
               void'(climb(pos));
            end
         end
         FUNC_POP: begin
            if (heap_fill == 0) r.status = STAT_EMPTY;
            else begin
               r.top_id = heap_ids[0];
               r.top_key = heap_keys[0];
               id_held[heap_ids[0]] = 0;
               heap_fill--;
               if (heap_fill > 0) begin
                  heap_ids[0] = heap_ids[heap_fill];
                  heap_keys[0] = heap_keys[heap_fill];
                  id_slot[heap_ids[0]] = 0;
                  sink(0);
               end
            end
         end
         FUNC_DEC, FUNC_INC: begin
            if (!id_held[id]) r.status = STAT_ABSENT;
            else begin
               pos = id_slot[id];
               heap_keys[pos] = key;
               if (!climb(pos)) sink(pos);
            end
         end
         FUNC_CLEAR: empty_heap();
         default: ;
      endcase
      r.entry_count = heap_fill[COUNT_BITS-1:0];
      return r;
   endfunction

   // response checker
   always @(posedge clock) begin
      heap_reply_type want;
      if (!reset && rsp_strobe) begin
         if (pending_replies.size() == 0) begin
            $error("unexpected response status=%0d", rsp_status);
            errors++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_status); errors++;
            end
            if (rsp_top_id !== want.top_id) begin
               $error("top_id expected %0d actual %0d", want.top_id, rsp_top_id); errors++;
            end
            if (rsp_top_key !== want.top_key) begin
               $error("top_key expected %0h actual %0h", want.top_key, rsp_top_key); errors++;
            end
            if (rsp_entry_count !== want.entry_count) begin
               $error("entry_count expected %0d actual %0d", want.entry_count,
                      rsp_entry_count);
               errors++;
            end
         end
      end
   end

   int burst_left = 0;

   task automatic send_request(logic [FUNC_BITS-1:0] func, logic [ID_BITS-1:0] id,
                               logic [KEY_BITS-1:0] key, bit typed,
                               heap_reply_type typed_reply);
      heap_reply_type predicted;
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 1) ? $urandom_range(1, 30) : 0;
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      if (gap != 0) begin
         start <= 0;
         repeat (gap) @(negedge clock);
      end
      req_func <= func;
      req_item_id <= id;
      req_item_key <= key;
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = apply_request(func, id, key);
      if (typed && predicted !== typed_reply) begin
         $error("table row func=%0d expected %p predictor %p", func, typed_reply, predicted);
         errors++;
      end
      pending_replies.push_back(predicted);
      @(negedge clock);
   endtask

   task automatic drain_and_set_order(bit order);
      start <= 0;
      while (pending_replies.size() != 0) @(negedge clock);
      while (busy) @(negedge clock);
      csr_wdata <= order;
      csr_we <= 1;
      @(negedge clock);
      csr_we <= 0;
      smallest_on_top = order;
   endtask

   function automatic heap_reply_type reply_of(int st, int id, logic [KEY_BITS-1:0] key,
                                               int cnt);
      heap_reply_type r;
      r.status = STAT_BITS'(st);
      r.top_id = ID_BITS'(id);
      r.top_key = key;
      r.entry_count = COUNT_BITS'(cnt);
      return r;
   endfunction

   // run a sequence of random requests mostly over a bounded id pool, with an occasional id from the full range
   task automatic random_phase(int count, int id_span, int key_span);
      logic [FUNC_BITS-1:0] f;
      int sel;
      logic [ID_BITS-1:0] id;
      logic [KEY_BITS-1:0] key;
      repeat (count) begin
         sel = $urandom_range(0, 99);
         if (sel < 45) f = FUNC_PUSH;
         else if (sel < 75) f = FUNC_POP;
         else if (sel < 86) f = FUNC_DEC;
         else if (sel < 97) f = FUNC_INC;
         else if (sel < 98) f = FUNC_CLEAR;
         else f = FUNC_BITS'($urandom_range(5, 7));
         id = ($urandom_range(0, 9) == 0) ? ID_BITS'($urandom)
                                          : ID_BITS'($urandom_range(0, id_span));
         key = (key_span == 0) ? $urandom : $urandom_range(0, key_span);
         if ((f == FUNC_DEC || f == FUNC_INC) && heap_fill > 0 && $urandom_range(0, 3) != 0)
            id = heap_ids[$urandom_range(0, heap_fill - 1)];
         send_request(f, id, key, 0, '0);
      end
   endtask

   stim_row_type rows[$];

   initial begin
      stim_row_type r;
      smallest_on_top = 1;
      empty_heap();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed table
      rows = '{
         '{FUNC_POP,   10'd0,    32'd0,          1, reply_of(STAT_EMPTY, 0, 0, 0)},
         '{FUNC_DEC,   10'd5,    32'd1,          1, reply_of(STAT_ABSENT, 0, 0, 0)},
         '{FUNC_PUSH,  10'd1023, 32'hFFFF_FFFF,  1, reply_of(STAT_OK, 0, 0, 1)},
         '{FUNC_PUSH,  10'd0,    32'd0,          1, reply_of(STAT_OK, 0, 0, 2)},
         '{FUNC_PUSH,  10'd0,    32'd7,          1, reply_of(STAT_PRESENT, 0, 0, 2)},
         '{FUNC_PUSH,  10'd512,  32'd100,        0, '0},
         '{FUNC_PUSH,  10'd341,  32'd100,        0, '0},
         '{FUNC_PUSH,  10'd682,  32'h8000_0000,  0, '0},
         '{FUNC_INC,   10'd0,    32'd200,        0, '0},
         '{FUNC_DEC,   10'd1023, 32'd1,          0, '0},
         '{FUNC_INC,   10'd512,  32'd50,         0, '0},
         '{FUNC_DEC,   10'd341,  32'hFFFF_FFFE,  0, '0},
         '{3'd5,       10'd3,    32'd3,          0, '0},
         '{3'd7,       10'd3,    32'd3,          0, '0},
         '{FUNC_POP,   10'd0,    32'd0,          0, '0},
         '{FUNC_POP,   10'd0,    32'd0,          0, '0},
         '{FUNC_CLEAR, 10'd0,    32'd0,          1, reply_of(STAT_OK, 0, 0, 0)},
         '{FUNC_POP,   10'd0,    32'd0,          1, reply_of(STAT_EMPTY, 0, 0, 0)},
         '{FUNC_INC,   10'd682,  32'd1,          1, reply_of(STAT_ABSENT, 0, 0, 0)}
      };
      foreach (rows[i]) begin
         r = rows[i];
         send_request(r.func, r.id, r.key, r.typed, r.reply);
      end

      // fill to capacity and overflow
      for (int i = 0; i < CAPACITY; i++)
         send_request(FUNC_PUSH, ID_BITS'(i * 4 + 1), $urandom, 0, '0);
      send_request(FUNC_PUSH, 10'd2, 32'd5, 1, reply_of(STAT_FULL, 0, 0, CAPACITY));
      repeat (20) send_request(FUNC_POP, '0, '0, 0, '0);
      send_request(FUNC_CLEAR, '0, '0, 0, '0);

      drain_and_set_order(0);
      random_phase(200, 40, 0);
      random_phase(100, 20, 15);
      drain_and_set_order(1);
      random_phase(200, 60, 0);
      random_phase(100, 15, 10);
      drain_and_set_order(0);
      random_phase(200, 1023, 0);
      drain_and_set_order(1);
      random_phase(250, 300, 1000);

      start <= 0;
      while (pending_replies.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (errors == 0 && pending_replies.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #(4ns * 400000);
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
